>>> hw/rtl/rwnh_pkg.sv
// Shared types, constants and helper functions of the nearest wall hit block.
`default_nettype none
package rwnh_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int VAL_W   = 24;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int TOL_W   = 16;
    localparam int FAR_W   = 23;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 3;
    localparam int WIDE_W  = 64;

    localparam logic [CIDX_W-1:0] REG_ACTIVE_LINES = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FORWARD_X    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FORWARD_Y    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_EDGE_TOL     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FAR_DISTANCE = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [SLOT_W-1:0]       slot;
        logic                    vertical;
        logic signed [VAL_W-1:0] wall_offset;
        logic signed [VAL_W-1:0] span_low;
        logic signed [VAL_W-1:0] span_high;
        logic signed [VAL_W-1:0] tex_start;
        logic signed [VAL_W-1:0] tex_end;
        logic signed [VAL_W-1:0] ray_x;
        logic signed [VAL_W-1:0] ray_y;
    } in_word_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] hit_x;
        logic signed [VAL_W-1:0] hit_y;
        logic signed [VAL_W-1:0] distance;
        logic signed [VAL_W-1:0] tex_coord;
        logic [SLOT_W-1:0]       hit_slot;
    } out_word_t;

    typedef struct packed {
        logic                    vertical;
        logic signed [VAL_W-1:0] offset;
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
        logic signed [VAL_W-1:0] tex_start;
        logic signed [VAL_W-1:0] tex_end;
    } seg_t;

    // Clamps a wide signed value to the 24-bit signed range.
    function automatic logic signed [VAL_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        hi_lim = WIDE_W'(64'sd8388607);
        lo_lim = -WIDE_W'(64'sd8388608);
        if (v > hi_lim) begin
            return VAL_W'(hi_lim);
        end else if (v < lo_lim) begin
            return VAL_W'(lo_lim);
        end
        return VAL_W'(v);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ray_wall_nearest_hit.sv
// Top level: segment table, sequencer walking the segments, shared divider and multiplier.
//
//  channel | ports                         | word
//  --------+-------------------------------+-----------------------------
//  input   | s_valid, s_ready, s_data      | write segment or cast ray
//  result  | m_valid, m_ready, m_data      | nearest hit, one per cast
//  config  | cfg_wr_en, cfg_index, cfg_wdata | register write, no wait
//
// A write word is taken while idle and the block stays ready for the next word. A cast is
// worked through the tested segments one after another; per segment at most two divisions in
// the shared bit-serial divider dominate the time, and each product goes through the multiplier.
// Reset is synchronous and active low; the table is not cleared.
// A finished result waits in the output register; the next word is taken meanwhile.
`default_nettype none
module ray_wall_nearest_hit
    import rwnh_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NUM_W = 26 + FRAC_BITS;
    localparam int DEN_W = 25;
    localparam int X_W   = 25;
    localparam int PW    = X_W + NUM_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_RD   = 12'b000000000010,
        S_CHK  = 12'b000000000100,
        S_DIV1 = 12'b000000001000,
        S_MUL1 = 12'b000000010000,
        S_SPAN = 12'b000000100000,
        S_DIV2 = 12'b000001000000,
        S_MUL2 = 12'b000010000000,
        S_DOTX = 12'b000100000000,
        S_DOTY = 12'b001000000000,
        S_NEXT = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        active_reg;
    logic signed [VAL_W-1:0] fwd_x_reg;
    logic signed [VAL_W-1:0] fwd_y_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [FAR_W-1:0]        far_reg;

    logic signed [VAL_W-1:0] rx_reg, ry_reg;
    logic [CNT_W-1:0]        n_reg, i_reg;
    logic signed [VAL_W-1:0] w_reg, tex_reg;
    logic signed [PW-1:0]    p1_reg;
    logic                    found_reg;
    logic signed [VAL_W-1:0] best_x_reg, best_y_reg, best_d_reg, best_tex_reg;
    logic [SLOT_W-1:0]       best_slot_reg;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    seg_t                    wr_seg, seg;
    logic                    mem_we;
    logic                    slot_ok;

    logic                    div_start, div_done;
    logic signed [NUM_W-1:0] div_num, div_q;
    logic signed [DEN_W-1:0] div_den;
    logic                    mac_start, mac_done;
    logic signed [X_W-1:0]   mac_x;
    logic signed [NUM_W-1:0] mac_y;
    logic signed [PW-1:0]    mac_p;

    logic signed [VAL_W-1:0] a_v, b_v, hx, hy;
    logic signed [X_W-1:0]   a_e, tol_e;
    logic                    near_par;
    logic signed [X_W:0]     w_e, lo_e, hi_e;
    logic                    span_ok;
    logic signed [VAL_W-1:0] w_sat, tex_sat, d_sat;
    logic signed [X_W-1:0]   dt;
    logic [CNT_W-1:0]        n_clip;
    logic                    accept;
    logic                    out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign slot_ok  = ({{(32-SLOT_W){1'b0}}, s_data.slot} < 32'(MAX_SEGMENTS));
    assign mem_we   = accept && (s_data.op == OP_WRITE) && slot_ok;
    assign n_clip   = (32'(active_reg) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : active_reg;

    always_comb begin
        wr_seg.vertical  = s_data.vertical;
        wr_seg.offset    = s_data.wall_offset;
        wr_seg.low       = s_data.span_low;
        wr_seg.high      = s_data.span_high;
        wr_seg.tex_start = s_data.tex_start;
        wr_seg.tex_end   = s_data.tex_end;
    end

    rwnh_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (AW'(s_data.slot)),
        .wr_data (wr_seg),
        .rd_addr (AW'(i_reg)),
        .rd_data (seg)
    );

    rwnh_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    rwnh_mac #(.X_W(X_W), .Y_W(NUM_W)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .x       (mac_x),
        .y       (mac_y),
        .done    (mac_done),
        .prod    (mac_p)
    );

    // Datapath: the segment word stays on the read port for the whole segment.
    always_comb begin
        a_v      = seg.vertical ? rx_reg : ry_reg;
        b_v      = seg.vertical ? ry_reg : rx_reg;
        hx       = seg.vertical ? seg.offset : w_reg;
        hy       = seg.vertical ? w_reg : seg.offset;
        a_e      = X_W'(a_v);
        tol_e    = $signed({{(X_W-TOL_W){1'b0}}, tol_reg});
        near_par = (a_e <= tol_e) && (a_e >= -tol_e);
        w_e      = (X_W+1)'(w_reg);
        lo_e     = (X_W+1)'(seg.low);
        hi_e     = (X_W+1)'(seg.high);
        span_ok  = (lo_e <= w_e + (X_W+1)'(tol_e)) && (w_e - (X_W+1)'(tol_e) <= hi_e);
        dt       = X_W'(seg.tex_end) - X_W'(seg.tex_start);
        w_sat    = sat24(WIDE_W'(mac_p >>> FRAC_BITS));
        tex_sat  = sat24(WIDE_W'(mac_p >>> FRAC_BITS) + WIDE_W'(seg.tex_start));
        d_sat    = sat24(WIDE_W'(p1_reg + mac_p) >>> FRAC_BITS);

        if (state_reg == S_SPAN) begin
            div_num = NUM_W'(w_e - lo_e) <<< FRAC_BITS;
            div_den = DEN_W'(hi_e - lo_e);
        end else begin
            div_num = NUM_W'(seg.offset) <<< FRAC_BITS;
            div_den = DEN_W'(a_e);
        end

        if (state_reg == S_DIV1) begin
            mac_x = X_W'(b_v);
            mac_y = div_q;
        end else if (state_reg == S_DIV2) begin
            mac_x = dt;
            mac_y = div_q;
        end else if (state_reg == S_DOTX) begin
            mac_x = X_W'(hy);
            mac_y = NUM_W'(fwd_y_reg);
        end else begin
            mac_x = X_W'(hx);
            mac_y = NUM_W'(fwd_x_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        mac_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_data.op == OP_CAST)) begin
                    state_next = (n_clip == '0) ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (near_par) begin
                    state_next = S_NEXT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    if (!div_q[NUM_W-1] && (div_q != '0)) begin
                        mac_start  = 1'b1;
                        state_next = S_MUL1;
                    end else begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_MUL1: begin
                if (mac_done) begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN: begin
                if (!span_ok) begin
                    state_next = S_NEXT;
                end else if (seg.high == seg.low) begin
                    mac_start  = 1'b1;
                    state_next = S_DOTX;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    mac_start  = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mac_done) begin
                    mac_start  = 1'b1;
                    state_next = S_DOTX;
                end
            end
            S_DOTX: begin
                if (mac_done) begin
                    mac_start  = 1'b1;
                    state_next = S_DOTY;
                end
            end
            S_DOTY: begin
                if (mac_done) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                state_next = (i_reg + 1'b1 >= n_reg) ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= '0;
            fwd_x_reg   <= '0;
            fwd_y_reg   <= VAL_W'(256);
            tol_reg     <= TOL_W'(16);
            far_reg     <= FAR_W'(25600);
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ACTIVE_LINES: active_reg <= cfg_wdata[CNT_W-1:0];
                    REG_FORWARD_X:    fwd_x_reg  <= cfg_wdata[VAL_W-1:0];
                    REG_FORWARD_Y:    fwd_y_reg  <= cfg_wdata[VAL_W-1:0];
                    REG_EDGE_TOL:     tol_reg    <= cfg_wdata[TOL_W-1:0];
                    REG_FAR_DISTANCE: far_reg    <= cfg_wdata[FAR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && accept && (s_data.op == OP_CAST)) begin
            rx_reg        <= s_data.ray_x;
            ry_reg        <= s_data.ray_y;
            n_reg         <= n_clip;
            i_reg         <= '0;
            found_reg     <= 1'b0;
            best_d_reg    <= VAL_W'(far_reg);
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_tex_reg  <= '0;
            best_slot_reg <= '0;
        end
        if ((state_reg == S_MUL1) && mac_done) begin
            w_reg <= w_sat;
        end
        if ((state_reg == S_SPAN) && (seg.high == seg.low)) begin
            tex_reg <= seg.tex_start;
        end
        if ((state_reg == S_MUL2) && mac_done) begin
            tex_reg <= tex_sat;
        end
        if ((state_reg == S_DOTX) && mac_done) begin
            p1_reg <= mac_p;
        end
        // Strictly smaller only, so on a tie the lower slot keeps the hit.
        if ((state_reg == S_DOTY) && mac_done && (d_sat < best_d_reg)) begin
            found_reg     <= 1'b1;
            best_d_reg    <= d_sat;
            best_x_reg    <= hx;
            best_y_reg    <= hy;
            best_tex_reg  <= tex_reg;
            best_slot_reg <= i_reg[SLOT_W-1:0];
        end
        if (state_reg == S_NEXT) begin
            i_reg <= i_reg + 1'b1;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_data_reg.found     <= found_reg;
            m_data_reg.hit_x     <= best_x_reg;
            m_data_reg.hit_y     <= best_y_reg;
            m_data_reg.distance  <= best_d_reg;
            m_data_reg.tex_coord <= best_tex_reg;
            m_data_reg.hit_slot  <= best_slot_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider result arrived outside a division state");

    a_mac_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == S_MUL1 || state_reg == S_MUL2 ||
                      state_reg == S_DOTX || state_reg == S_DOTY))
        else $error("multiplier result arrived outside a multiply state");

    a_cast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.op == OP_CAST) |=> !s_ready)
        else $error("block ready again straight after taking a cast word");

endmodule
`default_nettype wire

>>> hw/rtl/rwnh_seg_mem.sv
// Segment table: one write port and one registered read port.
`default_nettype none
module rwnh_seg_mem
    import rwnh_pkg::*;
#(
    parameter int DEPTH = MAX_SEGMENTS_DEF,
    parameter int AW    = 4
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire seg_t          wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output seg_t               rd_data
);

    seg_t mem [0:DEPTH-1];
    seg_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rwnh_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module rwnh_div
    import rwnh_pkg::*;
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 25
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    output logic                         done,
    output logic signed [NUM_W-1:0]      quot
);

    localparam int MW  = NUM_W - 1;
    localparam int CTW = $clog2(MW + 1);

    logic [CTW-1:0]   cnt_reg;
    logic [MW-1:0]    quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dmag_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [NUM_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;

    always_comb begin
        nmag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        trial = {rem_reg, quo_reg[MW-1]};
        diff  = trial - {1'b0, dmag_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CTW'(MW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CTW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= nmag[MW-1:0];
            rem_reg  <= '0;
            dmag_reg <= dmag;
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
        end else if (cnt_reg != '0) begin
            if (!diff[DEN_W]) begin
                rem_reg <= diff[DEN_W-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule
`default_nettype wire

>>> hw/rtl/rwnh_mac.sv
// Signed multiplier built from a low and a high partial product, accumulated one after the other.
`default_nettype none
module rwnh_mac
    import rwnh_pkg::*;
#(
    parameter int X_W = 25,
    parameter int Y_W = 34
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [X_W-1:0]   x,
    input  wire logic signed [Y_W-1:0]   y,
    output logic                         done,
    output logic signed [X_W+Y_W-1:0]    prod
);

    localparam int YL = (Y_W + 1) / 2;
    localparam int YH = Y_W - YL;
    localparam int PW = X_W + Y_W;

    logic signed [X_W-1:0]  x_reg;
    logic signed [Y_W-1:0]  y_reg;
    logic signed [PW-1:0]   acc_reg;
    logic                   ph1_reg;
    logic                   ph2_reg;
    logic                   done_reg;
    logic signed [X_W+YL:0] pl;
    logic signed [X_W+YH-1:0] ph;

    always_comb begin
        pl = x_reg * $signed({1'b0, y_reg[YL-1:0]});
        ph = x_reg * $signed(y_reg[Y_W-1:YL]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph1_reg  <= start;
            ph2_reg  <= ph1_reg;
            done_reg <= ph2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x;
            y_reg <= y;
        end
        if (ph1_reg) begin
            acc_reg <= PW'(pl);
        end else if (ph2_reg) begin
            acc_reg <= acc_reg + (PW'(ph) <<< YL);
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the nearest axis-aligned wall hit block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import rwnh_pkg::*;

    localparam int SEGS       = 16;
    localparam int FRAC       = 8;
    localparam int ITEM_GOAL  = 1170;
    localparam int SETTLE     = 2000;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_word_t         m_data;
    logic              cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Shadow copy of the segment table and the registers.
    seg_t   wall_tab [SEGS];
    int     cur_lines = 0;
    longint cur_fwd_x = 0;
    longint cur_fwd_y = 256;
    longint cur_tol = 16;
    longint cur_far = 25600;

    out_word_t hit_q[$];
    int        n_bad = 0;
    int        n_sent = 0;
    int        burst_left = 0;

    int rdy_cnt = 0;
    int rdy_period = 8;
    int rdy_duty = 8;

    stim_row_t rows[$];

    ray_wall_nearest_hit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint clamp24(input longint v);
        if (v > 64'sd8388607) begin
            return 64'sd8388607;
        end else if (v < -64'sd8388608) begin
            return -64'sd8388608;
        end
        return v;
    endfunction

    // Walks the active segments and keeps the hit nearest along the forward vector.
    function automatic out_word_t nearest_hit(input in_word_t w);
        longint    rx, ry, p, lo, hi, a, b, m, wv, tex, hx, hy, d, q, dt, ts;
        longint    best, bx, by, bt;
        int        n, bs;
        bit        hit;
        out_word_t r;
        rx = w.ray_x;
        ry = w.ray_y;
        best = cur_far;
        bx = 0; by = 0; bt = 0; bs = 0; hit = 1'b0;
        n = (cur_lines > SEGS) ? SEGS : cur_lines;
        for (int i = 0; i < n; i++) begin
            p = wall_tab[i].offset;
            lo = wall_tab[i].low;
            hi = wall_tab[i].high;
            ts = wall_tab[i].tex_start;
            if (wall_tab[i].vertical) begin
                a = rx; b = ry;
            end else begin
                a = ry; b = rx;
            end
            if (a <= cur_tol && a >= -cur_tol) continue;
            m = (p * (64'sd1 << FRAC)) / a;
            if (m <= 0) continue;
            wv = clamp24((b * m) >>> FRAC);
            if (!(lo <= wv + cur_tol && wv - cur_tol <= hi)) continue;
            if (hi == lo) begin
                tex = ts;
            end else begin
                q = ((wv - lo) * (64'sd1 << FRAC)) / (hi - lo);
                dt = longint'(wall_tab[i].tex_end) - ts;
                tex = clamp24(((q * dt) >>> FRAC) + ts);
            end
            if (wall_tab[i].vertical) begin
                hx = p; hy = wv;
            end else begin
                hx = wv; hy = p;
            end
            d = clamp24((hx * cur_fwd_x + hy * cur_fwd_y) >>> FRAC);
            if (d < best) begin
                hit = 1'b1; best = d; bx = hx; by = hy; bt = tex; bs = i;
            end
        end
        r.found = hit;
        r.hit_x = bx[VAL_W-1:0];
        r.hit_y = by[VAL_W-1:0];
        r.distance = best[VAL_W-1:0];
        r.tex_coord = bt[VAL_W-1:0];
        r.hit_slot = bs[SLOT_W-1:0];
        return r;
    endfunction

    function automatic in_word_t wall_word(input int slot, input bit vert, input int off,
                                           input int lo, input int hi, input int ts,
                                           input int te);
        in_word_t w;
        w = in_word_t'($urandom());
        w.op = OP_WRITE;
        w.slot = slot[SLOT_W-1:0];
        w.vertical = vert;
        w.wall_offset = off[VAL_W-1:0];
        w.span_low = lo[VAL_W-1:0];
        w.span_high = hi[VAL_W-1:0];
        w.tex_start = ts[VAL_W-1:0];
        w.tex_end = te[VAL_W-1:0];
        return w;
    endfunction

    function automatic in_word_t ray_word(input int x, input int y);
        in_word_t w;
        w = in_word_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom()});
        w.op = OP_CAST;
        w.ray_x = x[VAL_W-1:0];
        w.ray_y = y[VAL_W-1:0];
        return w;
    endfunction

    function automatic int rand_small(input int lim);
        int v;
        v = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic int rand_full();
        logic [VAL_W-1:0] v;
        v = VAL_W'($urandom());
        return int'($signed(v));
    endfunction

    // Registers are written one per cycle; the predictor follows at once.
    task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ACTIVE_LINES: cur_lines = val[CNT_W-1:0];
            REG_FORWARD_X:    cur_fwd_x = longint'($signed(val[VAL_W-1:0]));
            REG_FORWARD_Y:    cur_fwd_y = longint'($signed(val[VAL_W-1:0]));
            REG_EDGE_TOL:     cur_tol = val[TOL_W-1:0];
            REG_FAR_DISTANCE: cur_far = val[FAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (hit_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        burst_left--;
        n_sent++;
        if (w.op == OP_WRITE) begin
            wall_tab[w.slot] = '{w.vertical, w.wall_offset, w.span_low, w.span_high,
                                 w.tex_start, w.tex_end};
        end else begin
            hit_q.push_back(typed ? want : nearest_hit(w));
        end
    endtask

    // Result side: checks each word against the oldest expectation and drives m_ready in random bursts.
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (hit_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result word %h", m_data);
            end else begin
                e = hit_q.pop_front();
                if (m_data !== e) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("mismatch: found %0d/%0d x %0d/%0d y %0d/%0d dist %0d/%0d",
                                 e.found, m_data.found, e.hit_x, m_data.hit_x, e.hit_y,
                                 m_data.hit_y, e.distance, m_data.distance);
                        $display("          tex %0d/%0d slot %0d/%0d (expected/actual)",
                                 e.tex_coord, m_data.tex_coord, e.hit_slot,
                                 m_data.hit_slot);
                    end
                end
            end
        end
        rdy_cnt++;
        if (rdy_cnt >= rdy_period) begin
            rdy_cnt = 0;
            rdy_period = $urandom_range(1, 40);
            rdy_duty = $urandom_range(0, 3) == 0 ? rdy_period : $urandom_range(0, rdy_period);
        end
        m_ready <= aresetn && (rdy_cnt < rdy_duty);
    end

    initial begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        out_word_t none;
        out_word_t no_hit;
        stim_row_t row;
        in_word_t  w;
        int        ph, lines, cnt, s;
        none = '0;
        no_hit = '0;
        no_hit.distance = 24'd25600;

        // Directed rows. With the reset count of zero no segment is tested, so
        // the first cast is a plain miss at the reset far distance.
        rows.push_back('{ray_word(0, 256), 1'b1, no_hit});
        for (int i = 0; i < SEGS; i++) begin
            w = wall_word(i, i[0], (i[1] ? -1 : 1) * (512 + 64 * i), -2048, 2048, 0, 4096);
            rows.push_back('{w, 1'b0, none});
        end
        // Zero-length span, a tied pair and the field extremes.
        rows[6].w = wall_word(5, 1'b0, 700, 0, 0, 1234, -99);
        rows[8].w = wall_word(7, 1'b1, 600, -4096, 4096, -8388608, 8388607);
        rows[9].w = wall_word(8, 1'b1, 600, -4096, 4096, 55, 66);
        rows[15].w = wall_word(14, 1'b0, -8388608, -8388608, 8388607, 8388607, -8388608);
        rows[16].w = wall_word(15, 1'b1, 8388607, -8388608, 8388607, -8388608, 8388607);
        rows.push_back('{ray_word(256, 256), 1'b1, no_hit});
        rows.push_back('{ray_word(0, 256), 1'b0, none});
        rows.push_back('{ray_word(256, 10), 1'b0, none});
        rows.push_back('{ray_word(0, -256), 1'b0, none});
        rows.push_back('{ray_word(5, -5), 1'b0, none});
        rows.push_back('{ray_word(8388607, 8388607), 1'b0, none});
        rows.push_back('{ray_word(-8388608, -8388608), 1'b0, none});
        rows.push_back('{ray_word(-300, 200), 1'b0, none});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < rows.size(); i++) begin
            if (i == 18) begin
                s_valid <= 1'b0;
                wait_idle();
                set_reg(REG_ACTIVE_LINES, 24'd16);
                set_reg(REG_FAR_DISTANCE, 24'h7FFFFF);
            end
            row = rows[i];
            send_word(row.w, row.typed, row.want);
        end

        ph = 0;
        while (n_sent < ITEM_GOAL) begin
            s_valid <= 1'b0;
            wait_idle();
            // Every fifth phase pushes the registers to their extremes.
            if (ph % 5 == 4) begin
                lines = $urandom_range(0, 1) ? 31 : 16;
                set_reg(REG_ACTIVE_LINES, CFG_W'(lines));
                set_reg(REG_FORWARD_X, $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
                set_reg(REG_FORWARD_Y, $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
                set_reg(REG_EDGE_TOL, $urandom_range(0, 1) ? 24'h00FFFF : 24'h0);
                set_reg(REG_FAR_DISTANCE, $urandom_range(0, 1) ? 24'h7FFFFF : 24'h0);
            end else begin
                lines = $urandom_range(0, 3) == 0 ? $urandom_range(7, 31) : $urandom_range(0, 6);
                set_reg(REG_ACTIVE_LINES, CFG_W'(lines));
                set_reg(REG_FORWARD_X, CFG_W'($urandom_range(0, 7) == 0 ? $urandom()
                                                                        : rand_small(512)));
                set_reg(REG_FORWARD_Y, CFG_W'($urandom_range(0, 7) == 0 ? $urandom()
                                                                        : rand_small(512)));
                set_reg(REG_EDGE_TOL, CFG_W'($urandom_range(0, 7) == 0 ? $urandom()
                                                                       : $urandom_range(0, 64)));
                set_reg(REG_FAR_DISTANCE,
                        CFG_W'($urandom_range(0, 7) == 0 ? $urandom()
                                                         : $urandom_range(0, 65536)));
            end
            // Writes to the spare indexes must leave every register alone.
            set_reg(CIDX_W'($urandom_range(5, 7)), CFG_W'($urandom()));
            cnt = $urandom_range(40, 120);
            for (int k = 0; k < cnt; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    s = $urandom_range(0, SEGS - 1);
                    if ($urandom_range(0, 6) == 0) begin
                        w = wall_word(s, 1'($urandom_range(0, 1)), rand_full(), rand_full(),
                                      rand_full(), rand_full(), rand_full());
                    end else begin
                        lines = -$urandom_range(0, 8192);
                        w = wall_word(s, 1'($urandom_range(0, 1)), rand_small(8192), lines,
                                      $urandom_range(0, 5) == 0 ? lines
                                          : lines + $urandom_range(0, 16384),
                                      rand_small(4096), rand_small(4096));
                    end
                end else if ($urandom_range(0, 6) == 0) begin
                    w = ray_word(rand_full(), rand_full());
                end else begin
                    w = ray_word(rand_small(1024), rand_small(1024));
                end
                send_word(w, 1'b0, none);
            end
            ph++;
        end
        s_valid <= 1'b0;

        while (hit_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (n_bad == 0 && hit_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
